/* src/gyro_yaw_integrator_top_assert.svh */
// Assertion macros for the gyro yaw integrator checker.
`ifndef GYRO_YAW_INTEGRATOR_TOP_ASSERT_SVH
`define GYRO_YAW_INTEGRATOR_TOP_ASSERT_SVH

// ante implies cons in the same cycle
`define GYI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define GYI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/gyi_pkg.sv */
package gyi_pkg;

    localparam int GZ_W      = 16;
    localparam int YAW_W     = 32;
    localparam int RATE_W    = 14;
    localparam int CNT_W     = 16;
    localparam int SUM_W     = 32;
    localparam int DIV_W     = 32;
    localparam int DVS_W     = 16;
    localparam int DT_W      = 16;
    localparam int FRAC_SHIFT = 15;
    localparam int MUL_W     = 32;
    localparam int DT_RECIP_SHIFT = 45;
    localparam int DQ_W      = 2 * MUL_W - DT_RECIP_SHIFT;

    localparam logic [CNT_W-1:0] CAL_DEFAULT = 16'd200;
    localparam logic [15:0]      DPS_SCALE   = 16'd25000;
    localparam logic [15:0]      RATE_SCALE  = 16'd2500;
    localparam logic [DVS_W-1:0] DT_DIVISOR  = 16'd10000;
    // floor(p / 10000) == (p * DT_RECIP) >> DT_RECIP_SHIFT for any p below 2^32
    localparam logic [MUL_W-1:0] DT_RECIP    = 32'd3518437209;

    typedef enum logic [1:0] {
        MODE_RESET  = 2'd0,
        MODE_CAL    = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* src/gyi_if.sv */
interface gyi_in_if;
    import gyi_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [1:0]             mode;
    logic signed [GZ_W-1:0] gyro_z;
    logic                   sample_ok;
    logic [DT_W-1:0]        elapsed_ms;

    modport source (output valid, mode, gyro_z, sample_ok, elapsed_ms, input ready);
    modport sink   (input valid, mode, gyro_z, sample_ok, elapsed_ms, output ready);
endinterface

interface gyi_out_if;
    import gyi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [YAW_W-1:0]  yaw_tenths;
    logic                     yaw_ok;
    logic signed [RATE_W-1:0] rate_tenths;
    logic signed [GZ_W-1:0]   gyro_z_echo;
    logic signed [GZ_W-1:0]   bias_now;
    logic                     cal_done;

    modport source (output valid, yaw_tenths, yaw_ok, rate_tenths, gyro_z_echo, bias_now,
                    cal_done, input ready);
    modport sink   (input valid, yaw_tenths, yaw_ok, rate_tenths, gyro_z_echo, bias_now,
                    cal_done, output ready);
endinterface

interface gyi_cfg_if;
    import gyi_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* src/gyi_div.sv */
module gyi_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gyi_pkg::div_req_t req,
    output gyi_pkg::div_rsp_t rsp
);
    import gyi_pkg::*;

    localparam int STEPS = DIV_W;
    localparam int CW    = $clog2(STEPS);

    logic [CW-1:0]    count_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // one restoring step per cycle, quotient shifts in from the bottom
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == CW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* src/gyro_yaw_integrator_top.sv */
// Gyro Z bias calibration and yaw integration.
// Channels: in_ch (mode, gyro_z, sample_ok, elapsed_ms), out_ch (one result item per
// input item), cfg_ch (writes cal_samples; always ready, write only while idle).
// All handshakes complete on a rising edge with valid and ready high.
// The item passes S_EXEC, S_RATE and S_FINISH into the output register for reset, plain
// calibration, a run ending with no good sample, ignored update and unused mode;
// an accepted yaw update also passes S_MUL_DPS, S_MUL_DT, S_SCALE and S_ACC, and the
// calibration item that ends a run with good samples waits in S_DIV on the 32-step
// radix-2 divider (bias = sum / count). The next item is taken once the block is back
// in S_IDLE at the earliest. A single 32x32 multiplier is shared by the scale steps;
// delta / 10000 is a reciprocal multiply.
// One item is in work at a time; in_ch.ready is high only when idle.
// The result sits in an output register, so the next item is taken while a result
// waits; if the receiver stalls, the following item holds in its last step until
// the output register is free.
// Reset: yaw 0 and not valid, bias 0, calibration counters 0, cal_samples 200,
// no result pending.
module gyro_yaw_integrator_top (
    input logic         clk,
    input logic         rst_n,
    gyi_in_if.sink      in_ch,
    gyi_out_if.source   out_ch,
    gyi_cfg_if.sink     cfg_ch
);
    import gyi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MUL_DPS,
        S_MUL_DT,
        S_SCALE,
        S_ACC,
        S_DIV,
        S_RATE,
        S_FINISH
    } state_t;

    state_t                   state_reg;
    logic [1:0]               mode_reg;
    logic signed [GZ_W-1:0]   gz_reg;
    logic                     ok_reg;
    logic [DT_W-1:0]          dt_reg;
    logic [YAW_W-1:0]         yaw_reg;
    logic                     yaw_ok_reg;
    logic signed [GZ_W-1:0]   bias_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]         att_reg;
    logic [CNT_W-1:0]         good_reg;
    logic [CNT_W-1:0]         cal_samples_reg;
    logic                     neg_reg;
    logic [15:0]              dps_reg;
    logic [MUL_W-1:0]         prod_reg;
    logic [DQ_W-1:0]          delta_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic                     done_reg;

    logic                     out_valid_reg;
    logic [YAW_W-1:0]         out_yaw_reg;
    logic                     out_yaw_ok_reg;
    logic signed [RATE_W-1:0] out_rate_reg;
    logic signed [GZ_W-1:0]   out_gz_reg;
    logic signed [GZ_W-1:0]   out_bias_reg;
    logic                     out_done_reg;

    logic [GZ_W:0]            diff;
    logic                     d_neg;
    logic [GZ_W:0]            d_abs;
    logic [15:0]              d_mag;
    logic [CNT_W-1:0]         target;
    logic [CNT_W-1:0]         att_new;
    logic [CNT_W-1:0]         good_new;
    logic signed [SUM_W-1:0]  sum_new;
    logic                     cal_complete;
    logic [SUM_W-1:0]         sum_abs;
    logic [MUL_W-1:0]         mul_a;
    logic [MUL_W-1:0]         mul_b;
    logic [2*MUL_W-1:0]       prod;
    logic [RATE_W-1:0]        rate_mag;
    logic signed [RATE_W-1:0] rate_val;
    logic [DIV_W-1:0]         q_signed;
    logic [YAW_W-1:0]         delta_ext;
    logic [YAW_W-1:0]         delta_signed;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    gyi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        diff  = {gz_reg[GZ_W-1], gz_reg} - {bias_reg[GZ_W-1], bias_reg};
        d_neg = diff[GZ_W];
        d_abs = d_neg ? (~diff + 1'b1) : diff;
        d_mag = d_abs[15:0];

        target       = (cal_samples_reg == '0) ? CAL_DEFAULT : cal_samples_reg;
        att_new      = att_reg + 1'b1;
        good_new     = ok_reg ? (good_reg + 1'b1) : good_reg;
        sum_new      = ok_reg ? (sum_reg + SUM_W'(gz_reg)) : sum_reg;
        cal_complete = att_new >= target;
        sum_abs      = sum_new[SUM_W-1] ? (~sum_new + 1'b1) : sum_new;

        unique case (state_reg)
            S_MUL_DPS:
            begin
                mul_a = MUL_W'(d_mag);
                mul_b = MUL_W'(DPS_SCALE);
            end
            S_RATE:
            begin
                mul_a = MUL_W'(d_mag);
                mul_b = MUL_W'(RATE_SCALE);
            end
            S_SCALE:
            begin
                mul_a = prod_reg;
                mul_b = DT_RECIP;
            end
            default:
            begin
                mul_a = MUL_W'(dps_reg);
                mul_b = MUL_W'(dt_reg);
            end
        endcase
        prod = mul_a * mul_b;

        // truncation toward zero: shift the magnitude, then restore the sign
        rate_mag     = prod[FRAC_SHIFT+RATE_W-1:FRAC_SHIFT];
        rate_val     = d_neg ? (~rate_mag + 1'b1) : rate_mag;
        q_signed     = neg_reg ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
        delta_ext    = YAW_W'(delta_reg);
        delta_signed = neg_reg ? (~delta_ext + 1'b1) : delta_ext;

        div_req.start    = (state_reg == S_EXEC) && (mode_t'(mode_reg) == MODE_CAL)
                           && cal_complete && (good_new != '0);
        div_req.dividend = sum_abs;
        div_req.divisor  = good_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= '0;
            gz_reg          <= '0;
            ok_reg          <= 1'b0;
            dt_reg          <= '0;
            yaw_reg         <= '0;
            yaw_ok_reg      <= 1'b0;
            bias_reg        <= '0;
            sum_reg         <= '0;
            att_reg         <= '0;
            good_reg        <= '0;
            cal_samples_reg <= CAL_DEFAULT;
            neg_reg         <= 1'b0;
            dps_reg         <= '0;
            prod_reg        <= '0;
            delta_reg       <= '0;
            rate_reg        <= '0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_yaw_reg     <= '0;
            out_yaw_ok_reg  <= 1'b0;
            out_rate_reg    <= '0;
            out_gz_reg      <= '0;
            out_bias_reg    <= '0;
            out_done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                cal_samples_reg <= cfg_ch.data;
            end
            if (out_ch.ready && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        mode_reg  <= in_ch.mode;
                        gz_reg    <= in_ch.gyro_z;
                        ok_reg    <= in_ch.sample_ok;
                        dt_reg    <= in_ch.elapsed_ms;
                        done_reg  <= 1'b0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_RATE;
                    unique case (mode_t'(mode_reg))
                        MODE_RESET:
                        begin
                            yaw_reg    <= '0;
                            yaw_ok_reg <= 1'b1;
                        end
                        MODE_CAL:
                        begin
                            if (cal_complete)
                            begin
                                att_reg    <= '0;
                                sum_reg    <= '0;
                                good_reg   <= '0;
                                yaw_reg    <= '0;
                                yaw_ok_reg <= 1'b1;
                                done_reg   <= 1'b1;
                                neg_reg    <= sum_new[SUM_W-1];
                                if (good_new != '0)
                                begin
                                    state_reg <= S_DIV;
                                end
                                else
                                begin
                                    bias_reg <= '0;
                                end
                            end
                            else
                            begin
                                att_reg  <= att_new;
                                sum_reg  <= sum_new;
                                good_reg <= good_new;
                            end
                        end
                        MODE_UPDATE:
                        begin
                            if (yaw_ok_reg && ok_reg)
                            begin
                                neg_reg   <= d_neg;
                                state_reg <= S_MUL_DPS;
                            end
                        end
                        MODE_NONE:
                        begin
                        end
                    endcase
                end
                S_MUL_DPS:
                begin
                    dps_reg   <= prod[FRAC_SHIFT+15:FRAC_SHIFT];
                    state_reg <= S_MUL_DT;
                end
                S_MUL_DT:
                begin
                    prod_reg  <= prod[MUL_W-1:0];
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    delta_reg <= prod[2*MUL_W-1:DT_RECIP_SHIFT];
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    yaw_reg   <= yaw_reg + delta_signed;
                    state_reg <= S_RATE;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        bias_reg  <= q_signed[GZ_W-1:0];
                        state_reg <= S_RATE;
                    end
                end
                S_RATE:
                begin
                    rate_reg  <= rate_val;
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_yaw_reg    <= yaw_reg;
                        out_yaw_ok_reg <= yaw_ok_reg;
                        out_rate_reg   <= rate_reg;
                        out_gz_reg     <= gz_reg;
                        out_bias_reg   <= bias_reg;
                        out_done_reg   <= done_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.yaw_tenths  = out_yaw_reg;
    assign out_ch.yaw_ok      = out_yaw_ok_reg;
    assign out_ch.rate_tenths = out_rate_reg;
    assign out_ch.gyro_z_echo = out_gz_reg;
    assign out_ch.bias_now    = out_bias_reg;
    assign out_ch.cal_done    = out_done_reg;

endmodule

/* src/gyi_checker.sv */
`include "gyro_yaw_integrator_top_assert.svh"

module gyi_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [gyi_pkg::YAW_W-1:0]  yaw_tenths,
    input logic                              yaw_ok,
    input logic signed [gyi_pkg::RATE_W-1:0] rate_tenths,
    input logic                              cal_done
);
    import gyi_pkg::*;

    `GYI_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
    `GYI_ASSERT_IMP(a_cal_clears_yaw, out_valid && cal_done, yaw_ok && (yaw_tenths == '0), "calibration did not clear yaw")
    `GYI_ASSERT_IMP(a_rate_range, out_valid, (rate_tenths <= 14'sd4999) && (rate_tenths >= -14'sd4999), "rate out of range")
    `GYI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(yaw_tenths) && $stable(rate_tenths), "stalled result changed")

endmodule

bind gyro_yaw_integrator_top gyi_checker u_gyi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .yaw_tenths  (out_ch.yaw_tenths),
    .yaw_ok      (out_ch.yaw_ok),
    .rate_tenths (out_ch.rate_tenths),
    .cal_done    (out_ch.cal_done)
);
